### rtl/sfol_pkg.sv
// Shared types and constants for the serial frame output latch.
// No dependencies; used by serial_frame_output_latch_core.
package sfol_pkg;

    // Received character codes
    localparam logic [7:0] CHAR_PERCENT = 8'h25;   // '%'
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;   // '$'
    localparam logic [7:0] CHAR_AT      = 8'h40;   // '@'
    localparam logic [7:0] CHAR_D       = 8'h44;   // 'D'
    localparam logic [7:0] CHAR_R       = 8'h52;   // 'R'
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;

    // Register reset values
    localparam logic [7:0] STATION_ADDR_RST  = 8'h40;
    localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd10;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDR  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT = 1'b1;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Body byte positions after the address
    localparam logic [2:0] IDX_HDR_D     = 3'd0;
    localparam logic [2:0] IDX_HDR_R     = 3'd1;
    localparam logic [2:0] IDX_CAP_FIRST = 3'd3;
    localparam logic [2:0] IDX_CAP_LAST  = 3'd5;
    localparam logic [2:0] IDX_LAST_DATA = 3'd6;

    // Frame phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ADDR = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

endpackage

### rtl/serial_frame_output_latch_core.sv
// Top level of the serial frame output latch: frame parser, tick timeout, result register.
// Depends on sfol_pkg.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_action, s_rx_byte
//  m_       out        m_valid / m_ready    m_pin_levels, m_indicator_on,
//                                           m_frame_accepted, m_line_active
//  cfg_     in         cfg_we (no wait)     cfg_index, cfg_wdata
//
// One request per cycle while s_ready is high; its result is loaded into the result register on accept.
// Throughput is set by the single result register: s_ready = !m_valid || m_ready.
// Synchronous active-low reset clears all control state and m_valid; the output payload registers are not reset.
// A stalled result holds the register and stops input accept until it is taken.
module serial_frame_output_latch_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pin_levels,
    output logic        m_indicator_on,
    output logic        m_frame_accepted,
    output logic        m_line_active,
    input  logic        cfg_we,
    input  logic [sfol_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0]       station_addr_reg;
    logic [7:0]       timeout_limit_reg;

    sfol_pkg::phase_t phase_reg, phase_next;
    logic             addr_pend_reg, addr_pend_next;
    logic             start_arm_reg, start_arm_next;
    logic             end_arm_reg, end_arm_next;
    logic [2:0]       byte_idx_reg, byte_idx_next;
    logic [3:0]       cap_reg [3];
    logic [15:0]      nibbles_reg, nibbles_next;
    logic [7:0]       tick_reg, tick_next;
    logic             ind_reg, ind_next;
    logic             line_reg, line_next;
    logic             accepted_next;

    logic             m_valid_reg;
    logic [15:0]      m_pins_reg;
    logic             m_ind_reg;
    logic             m_acc_reg;
    logic             m_line_reg;

    logic             s_fire;
    logic [7:0]       tick_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign tick_inc = tick_reg + 8'd1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_addr_reg  <= sfol_pkg::STATION_ADDR_RST;
            timeout_limit_reg <= sfol_pkg::TIMEOUT_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sfol_pkg::REG_STATION_ADDR:  station_addr_reg  <= cfg_wdata;
                sfol_pkg::REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state for one request: tick timeout, or frame advance, then start code, then end code
    always_comb begin
        phase_next     = phase_reg;
        addr_pend_next = addr_pend_reg;
        start_arm_next = start_arm_reg;
        end_arm_next   = end_arm_reg;
        byte_idx_next  = byte_idx_reg;
        nibbles_next   = nibbles_reg;
        tick_next      = tick_reg;
        ind_next       = ind_reg;
        line_next      = line_reg;
        accepted_next  = 1'b0;

        if (s_action == sfol_pkg::ACT_TICK) begin
            // count ticks, clear pins and indicator past the limit
            tick_next = tick_inc;
            if (tick_inc > timeout_limit_reg) begin
                tick_next    = 8'd0;
                nibbles_next = 16'd0;
                ind_next     = 1'b0;
            end
        end else begin
            case (phase_reg)
                sfol_pkg::PH_ADDR: begin
                    if (addr_pend_reg) begin
                        if (s_rx_byte == station_addr_reg) begin
                            phase_next    = sfol_pkg::PH_BODY;
                            byte_idx_next = 3'd0;
                        end else begin
                            phase_next = sfol_pkg::PH_IDLE;
                        end
                        addr_pend_next = 1'b0;
                    end else if (s_rx_byte == sfol_pkg::CHAR_AT) begin
                        addr_pend_next = 1'b1;
                    end
                end
                sfol_pkg::PH_BODY: begin
                    // check header, drop frame on mismatch
                    if (byte_idx_reg == sfol_pkg::IDX_HDR_D ||
                        byte_idx_reg == sfol_pkg::IDX_HDR_R) begin
                        if ((byte_idx_reg == sfol_pkg::IDX_HDR_D &&
                             s_rx_byte != sfol_pkg::CHAR_D) ||
                            (byte_idx_reg == sfol_pkg::IDX_HDR_R &&
                             s_rx_byte != sfol_pkg::CHAR_R)) begin
                            phase_next = sfol_pkg::PH_IDLE;
                            ind_next   = 1'b0;
                        end
                    end else if (byte_idx_reg >= sfol_pkg::IDX_LAST_DATA) begin
                        // last data byte: latch all four nibbles
                        nibbles_next  = {s_rx_byte[3:0], cap_reg[2], cap_reg[1], cap_reg[0]};
                        phase_next    = sfol_pkg::PH_IDLE;
                        tick_next     = 8'd0;
                        ind_next      = 1'b1;
                        accepted_next = 1'b1;
                    end
                    byte_idx_next = byte_idx_reg + 3'd1;
                end
                default: ;
            endcase

            // start code: '%' arms, a later '$' opens the frame
            if (start_arm_reg) begin
                if (s_rx_byte == sfol_pkg::CHAR_DOLLAR) begin
                    start_arm_next = 1'b0;
                    phase_next     = sfol_pkg::PH_ADDR;
                    byte_idx_next  = 3'd0;
                    line_next      = 1'b1;
                end
            end else if (s_rx_byte == sfol_pkg::CHAR_PERCENT) begin
                start_arm_next = 1'b1;
            end

            // end code: CR then LF drops line activity
            if (end_arm_reg) begin
                if (s_rx_byte == sfol_pkg::CHAR_LF) begin
                    end_arm_next = 1'b0;
                    line_next    = 1'b0;
                end
            end else if (s_rx_byte == sfol_pkg::CHAR_CR) begin
                end_arm_next = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= sfol_pkg::PH_IDLE;
            addr_pend_reg <= 1'b0;
            start_arm_reg <= 1'b0;
            end_arm_reg   <= 1'b0;
            byte_idx_reg  <= 3'd0;
            nibbles_reg   <= 16'd0;
            tick_reg      <= 8'd0;
            ind_reg       <= 1'b0;
            line_reg      <= 1'b0;
        end else if (s_fire) begin
            phase_reg     <= phase_next;
            addr_pend_reg <= addr_pend_next;
            start_arm_reg <= start_arm_next;
            end_arm_reg   <= end_arm_next;
            byte_idx_reg  <= byte_idx_next;
            nibbles_reg   <= nibbles_next;
            tick_reg      <= tick_next;
            ind_reg       <= ind_next;
            line_reg      <= line_next;
        end
    end

    // Capture low nibbles of body bytes three to five
    always_ff @(posedge aclk) begin
        if (s_fire && s_action == sfol_pkg::ACT_BYTE && phase_reg == sfol_pkg::PH_BODY &&
            byte_idx_reg >= sfol_pkg::IDX_CAP_FIRST &&
            byte_idx_reg <= sfol_pkg::IDX_CAP_LAST) begin
            cap_reg[2'(byte_idx_reg - sfol_pkg::IDX_CAP_FIRST)] <= s_rx_byte[3:0];
        end
    end

    // Result register: hold while stalled, load on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_pins_reg <= ~nibbles_next;
            m_ind_reg  <= ind_next;
            m_acc_reg  <= accepted_next;
            m_line_reg <= line_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pin_levels     = m_pins_reg;
    assign m_indicator_on   = m_ind_reg;
    assign m_frame_accepted = m_acc_reg;
    assign m_line_active    = m_line_reg;

    // Checks
    a_acc_has_ind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_acc_reg |-> m_ind_reg)
        else $error("frame accepted without indicator");

    a_tick_no_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_action == sfol_pkg::ACT_TICK |=> m_valid_reg && !m_acc_reg)
        else $error("tick reported a frame");

    a_last_byte_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_action == sfol_pkg::ACT_BYTE && phase_reg == sfol_pkg::PH_BODY &&
        byte_idx_reg >= sfol_pkg::IDX_LAST_DATA |=> m_acc_reg && m_pins_reg == ~nibbles_reg)
        else $error("last data byte did not latch outputs");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid after reset");

endmodule

### tb/tb_top.sv
// Self-checking testbench for serial_frame_output_latch_core: frame parsing, pin latch,
// tick timeout and line activity, checked against an in-bench predictor.
// Depends on sfol_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import sfol_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] pin_levels;
        logic        indicator_on;
        logic        frame_accepted;
        logic        line_active;
    } latch_result_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_RUNS
    } stall_mode_t;

    // DUT ports, inputs driven from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_action  = ACT_BYTE;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [15:0] m_pin_levels;
    logic        m_indicator_on;
    logic        m_frame_accepted;
    logic        m_line_active;
    logic        cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_STATION_ADDR;
    logic [7:0]  cfg_wdata = 8'h00;

    // Predictor state and its copy of the registers
    logic [7:0]  cfg_station  = STATION_ADDR_RST;
    logic [7:0]  cfg_timeout  = TIMEOUT_LIMIT_RST;
    phase_t      sim_phase    = PH_IDLE;
    logic        addr_pending = 1'b0;
    logic        start_seen   = 1'b0;
    logic        cr_seen      = 1'b0;
    logic [2:0]  body_pos     = 3'd0;
    logic [7:0]  body_capture [0:2];
    logic [3:0]  data_nibbles [0:3] = '{4'h0, 4'h0, 4'h0, 4'h0};
    logic [7:0]  tick_total   = 8'd0;
    logic        ind_state    = 1'b0;
    logic        line_state   = 1'b0;

    latch_result_t predicted_latch_results [$];

    // Stimulus shaping and bookkeeping
    int unsigned sent_count    = 0;
    int unsigned burst_left    = 0;
    int unsigned tick_pct      = 8;
    bit          gaps_enabled  = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;
    stall_mode_t stall_mode    = RX_ALWAYS;
    int unsigned mode_left     = 0;
    int unsigned hold_left     = 0;

    serial_frame_output_latch_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pin_levels     (m_pin_levels),
        .m_indicator_on   (m_indicator_on),
        .m_frame_accepted (m_frame_accepted),
        .m_line_active    (m_line_active),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the predicted latch state by one request and return its result
    function automatic latch_result_t compute_latch_result(input logic act, input logic [7:0] rx);
        latch_result_t r;
        logic [2:0] k;
        int i;
        r.frame_accepted = 1'b0;
        if (act == ACT_TICK) begin
            tick_total = tick_total + 8'd1;
            if (tick_total > cfg_timeout) begin
                tick_total = 8'd0;
                for (i = 0; i < 4; i++) data_nibbles[i] = 4'h0;
                ind_state = 1'b0;
            end
        end else begin
            // frame parser goes first
            case (sim_phase)
                PH_ADDR: begin
                    if (addr_pending) begin
                        if (rx == cfg_station) begin
                            sim_phase = PH_BODY;
                            body_pos = 3'd0;
                        end else begin
                            sim_phase = PH_IDLE;
                        end
                        addr_pending = 1'b0;
                    end else if (rx == CHAR_AT) begin
                        addr_pending = 1'b1;
                    end
                end
                PH_BODY: begin
                    k = body_pos;
                    if (k >= IDX_CAP_FIRST && k <= IDX_CAP_LAST)
                        body_capture[k - IDX_CAP_FIRST] = rx;
                    if (k == IDX_HDR_D || k == IDX_HDR_R) begin
                        if (rx != ((k == IDX_HDR_D) ? CHAR_D : CHAR_R)) begin
                            sim_phase = PH_IDLE;
                            ind_state = 1'b0;
                        end
                    end else if (k >= IDX_LAST_DATA) begin
                        data_nibbles[0] = body_capture[0][3:0];
                        data_nibbles[1] = body_capture[1][3:0];
                        data_nibbles[2] = body_capture[2][3:0];
                        data_nibbles[3] = rx[3:0];
                        sim_phase = PH_IDLE;
                        tick_total = 8'd0;
                        ind_state = 1'b1;
                        r.frame_accepted = 1'b1;
                    end
                    body_pos = k + 3'd1;
                end
                default: ;
            endcase
            // then the start code, then the end code
            if (start_seen) begin
                if (rx == CHAR_DOLLAR) begin
                    start_seen = 1'b0;
                    sim_phase = PH_ADDR;
                    body_pos = 3'd0;
                    line_state = 1'b1;
                end
            end else if (rx == CHAR_PERCENT) begin
                start_seen = 1'b1;
            end
            if (cr_seen) begin
                if (rx == CHAR_LF) begin
                    cr_seen = 1'b0;
                    line_state = 1'b0;
                end
            end else if (rx == CHAR_CR) begin
                cr_seen = 1'b1;
            end
        end
        for (i = 0; i < 16; i++) r.pin_levels[i] = ~data_nibbles[i / 4][i % 4];
        r.indicator_on = ind_state;
        r.line_active = line_state;
        return r;
    endfunction

    // Track register writes, check results, predict accepted requests
    always @(posedge aclk) begin
        latch_result_t got;
        latch_result_t want;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_index == REG_STATION_ADDR) cfg_station = cfg_wdata;
                else cfg_timeout = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                got.pin_levels     = m_pin_levels;
                got.indicator_on   = m_indicator_on;
                got.frame_accepted = m_frame_accepted;
                got.line_active    = m_line_active;
                if (predicted_latch_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request pending: pins %h", $time,
                                 got.pin_levels);
                end else begin
                    want = predicted_latch_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch pins exp %h got %h, indicator exp %b ",
                                      "got %b, accepted exp %b got %b, line exp %b got %b"},
                                     $time, want.pin_levels, got.pin_levels,
                                     want.indicator_on, got.indicator_on,
                                     want.frame_accepted, got.frame_accepted,
                                     want.line_active, got.line_active);
                    end
                end
            end
            if (s_valid && s_ready)
                predicted_latch_results.push_back(compute_latch_result(s_action, s_rx_byte));
        end
    end

    // Receiver: switch between always ready, random stalls and long runs
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(64, 256);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            RX_ALWAYS: m_ready = 1'b1;
            RX_RANDOM: m_ready = ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left == 0) begin
                    m_ready = !m_ready;
                    hold_left = $urandom_range(1, 15);
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one request and hold it until accepted; insert a gap after a burst when gaps are enabled
    task automatic send_request(input logic act, input logic [7:0] rx);
        @(negedge aclk);
        s_valid = 1'b1;
        s_action = act;
        s_rx_byte = rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        if (gaps_enabled) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                @(negedge aclk);
                s_valid = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_tick();
        send_request(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Send a byte, sometimes preceded by a timer tick
    task automatic send_rx(input logic [7:0] rx);
        if ($urandom_range(0, 99) < tick_pct) send_tick();
        send_request(ACT_BYTE, rx);
    endtask

    // Byte biased toward the codes the parser reacts to
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 11))
            0: return CHAR_PERCENT;
            1: return CHAR_DOLLAR;
            2: return CHAR_AT;
            3: return CHAR_D;
            4: return CHAR_R;
            5: return CHAR_CR;
            6: return CHAR_LF;
            7: return cfg_station;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Drain all pending results so the block is idle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (predicted_latch_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Mostly well-formed frames with random content, the rest noise and ticks
    task automatic send_random_traffic(input int unsigned n_items);
        int unsigned start_count;
        start_count = sent_count;
        while (sent_count - start_count < n_items) begin
            if ($urandom_range(0, 99) < 75) begin
                repeat ($urandom_range(0, 2)) send_rx(random_byte());
                send_rx(CHAR_PERCENT);
                // start code may lag the arm code by a few bytes
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
                    send_rx(random_byte());
                send_rx(CHAR_DOLLAR);
                if ($urandom_range(0, 4) == 0) send_rx(random_byte());
                send_rx(CHAR_AT);
                send_rx($urandom_range(0, 9) != 0 ? cfg_station : 8'($urandom_range(0, 255)));
                send_rx($urandom_range(0, 14) != 0 ? CHAR_D : random_byte());
                send_rx($urandom_range(0, 14) != 0 ? CHAR_R : random_byte());
                repeat (5)
                    send_rx($urandom_range(0, 19) != 0 ? 8'($urandom_range(0, 255))
                                                       : random_byte());
                case ($urandom_range(0, 3))
                    0: begin
                        send_rx(CHAR_CR);
                        send_rx(CHAR_LF);
                    end
                    1: begin
                        send_rx(CHAR_CR);
                        send_rx(random_byte());
                        send_rx(CHAR_LF);
                    end
                    default: ;
                endcase
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 2) == 0) send_tick();
                    else send_rx(random_byte());
                end
            end
        end
    endtask

    // Valid frame with sticky start code, extreme nibbles, an ignored tick byte, CR LF
    task automatic test_directed_frame();
        gaps_enabled = 1'b0;
        send_request(ACT_BYTE, CHAR_PERCENT);
        send_request(ACT_BYTE, 8'h00);
        send_request(ACT_BYTE, CHAR_DOLLAR);
        send_request(ACT_BYTE, CHAR_AT);
        send_request(ACT_BYTE, STATION_ADDR_RST);
        send_request(ACT_BYTE, CHAR_D);
        send_request(ACT_BYTE, CHAR_R);
        send_request(ACT_BYTE, 8'h5A);
        send_request(ACT_BYTE, 8'hF0);
        send_request(ACT_BYTE, 8'h0F);
        send_request(ACT_BYTE, 8'hFF);
        send_request(ACT_BYTE, 8'h00);
        send_request(ACT_TICK, 8'hFF);
        send_request(ACT_BYTE, CHAR_CR);
        send_request(ACT_BYTE, CHAR_LF);
    endtask

    // Start code inside a body, address mismatch, header mismatch
    task automatic test_header_faults();
        gaps_enabled = 1'b1;
        send_request(ACT_BYTE, CHAR_PERCENT);
        send_request(ACT_BYTE, CHAR_DOLLAR);
        send_request(ACT_BYTE, CHAR_AT);
        send_request(ACT_BYTE, STATION_ADDR_RST);
        send_request(ACT_BYTE, CHAR_D);
        send_request(ACT_BYTE, CHAR_R);
        send_request(ACT_BYTE, CHAR_PERCENT);
        send_request(ACT_BYTE, CHAR_DOLLAR);
        send_request(ACT_BYTE, CHAR_AT);
        send_request(ACT_BYTE, STATION_ADDR_RST + 8'd1);
        send_request(ACT_BYTE, CHAR_PERCENT);
        send_request(ACT_BYTE, CHAR_DOLLAR);
        send_request(ACT_BYTE, CHAR_AT);
        send_request(ACT_BYTE, STATION_ADDR_RST);
        send_request(ACT_BYTE, CHAR_D);
        send_request(ACT_BYTE, 8'h51);
    endtask

    // Zero timeout: a single tick clears the held pins
    task automatic test_tick_timeout();
        wait_idle();
        write_register(REG_TIMEOUT_LIMIT, 8'd0);
        send_tick();
        send_tick();
    endtask

    task automatic test_random_defaults();
        wait_idle();
        write_register(REG_STATION_ADDR, STATION_ADDR_RST);
        write_register(REG_TIMEOUT_LIMIT, TIMEOUT_LIMIT_RST);
        gaps_enabled = 1'b0;
        tick_pct = 8;
        send_random_traffic(150);
        gaps_enabled = 1'b1;
        send_random_traffic(150);
    endtask

    // Station addresses at the extremes and equal to the control codes
    task automatic test_random_addresses();
        logic [7:0] addr_list [0:5];
        int i;
        addr_list = '{8'h00, 8'hFF, CHAR_AT, CHAR_DOLLAR, CHAR_PERCENT,
                      8'($urandom_range(0, 255))};
        for (i = 0; i < 6; i++) begin
            wait_idle();
            write_register(REG_STATION_ADDR, addr_list[i]);
            write_register(REG_TIMEOUT_LIMIT, 8'($urandom_range(2, 20)));
            gaps_enabled = 1'($urandom_range(0, 1));
            tick_pct = $urandom_range(2, 15);
            send_random_traffic(150);
        end
    endtask

    // Timeout limits at the extremes, ticks frequent
    task automatic test_random_timeouts();
        logic [7:0] limit_list [0:3];
        int i;
        limit_list = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 8))};
        for (i = 0; i < 4; i++) begin
            wait_idle();
            write_register(REG_TIMEOUT_LIMIT, limit_list[i]);
            write_register(REG_STATION_ADDR, 8'($urandom_range(0, 255)));
            gaps_enabled = (i != 2);
            tick_pct = 30;
            send_random_traffic(175);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_frame();
        test_header_faults();
        test_tick_timeout();
        test_random_defaults();
        test_random_addresses();
        test_random_timeouts();

        wait_idle();
        repeat (4) @(posedge aclk);
        if (predicted_latch_results.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
